FILE: rtl/tccbs_pkg.sv
package tccbs_pkg;

    localparam int FRAME_WIDTH_BITS = 11;
    localparam logic [FRAME_WIDTH_BITS-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam int COUNT_BITS = 21;
    localparam int FIELD_SUM_BITS = 30;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int REG_INDEX_BITS = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 1'b0;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [7:0] BOUND_MIN_RESET = 8'd255;
    localparam logic [7:0] BOUND_MAX_RESET = 8'd0;

    typedef enum logic [1:0] {
        OP_CLASSIFY   = 2'd0,
        OP_LEARN_HAND = 2'd1,
        OP_LEARN_BAND = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CLASS_BACKGROUND = 2'd0,
        CLASS_HAND       = 2'd1,
        CLASS_BAND       = 2'd2,
        CLASS_LEARN      = 2'd3
    } pixel_class_t;

    typedef logic [2:0][7:0] channels_t;

    typedef struct packed {
        pixel_class_t pixel_class;
        logic         last;
    } item_ctrl_t;

endpackage

FILE: rtl/tccbs_front.sv
module tccbs_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic [1:0]                             operation,
    input  logic [7:0]                             blue,
    input  logic [7:0]                             green,
    input  logic [7:0]                             red,
    input  logic                                   frame_end,
    input  logic [tccbs_pkg::FRAME_WIDTH_BITS-1:0] frame_width,
    output tccbs_pkg::item_ctrl_t                  item_ctrl,
    output logic [COORD_BITS-1:0]                  item_col,
    output logic [COORD_BITS-1:0]                  item_row
);

    localparam int CW =
        (COORD_BITS > tccbs_pkg::FRAME_WIDTH_BITS ? COORD_BITS : tccbs_pkg::FRAME_WIDTH_BITS) + 1;

    tccbs_pkg::channels_t hand_min_reg, hand_min_next;
    tccbs_pkg::channels_t hand_max_reg, hand_max_next;
    tccbs_pkg::channels_t band_min_reg, band_min_next;
    tccbs_pkg::channels_t band_max_reg, band_max_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;

    tccbs_pkg::channels_t px;
    tccbs_pkg::pixel_class_t cls;
    logic hand_hit;
    logic band_hit;
    logic [tccbs_pkg::FRAME_WIDTH_BITS-1:0] width_eff;
    logic [CW-1:0] col_inc;
    logic wrap;

    assign px[0] = blue;
    assign px[1] = green;
    assign px[2] = red;

    always_comb
    begin
        hand_hit = 1'b1;
        band_hit = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            if (px[c] < hand_min_reg[c] || px[c] > hand_max_reg[c])
            begin
                hand_hit = 1'b0;
            end
            if (px[c] < band_min_reg[c] || px[c] > band_max_reg[c])
            begin
                band_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        hand_min_next = hand_min_reg;
        hand_max_next = hand_max_reg;
        band_min_next = band_min_reg;
        band_max_next = band_max_reg;
        case (tccbs_pkg::op_t'(operation))
            tccbs_pkg::OP_LEARN_HAND:
            begin
                cls = tccbs_pkg::CLASS_LEARN;
                for (int c = 0; c < 3; c++)
                begin
                    if (px[c] < hand_min_reg[c])
                    begin
                        hand_min_next[c] = px[c];
                    end
                    if (px[c] > hand_max_reg[c])
                    begin
                        hand_max_next[c] = px[c];
                    end
                end
            end
            tccbs_pkg::OP_LEARN_BAND:
            begin
                cls = tccbs_pkg::CLASS_LEARN;
                for (int c = 0; c < 3; c++)
                begin
                    if (px[c] < band_min_reg[c])
                    begin
                        band_min_next[c] = px[c];
                    end
                    if (px[c] > band_max_reg[c])
                    begin
                        band_max_next[c] = px[c];
                    end
                end
            end
            default:
            begin
                if (hand_hit)
                begin
                    cls = tccbs_pkg::CLASS_HAND;
                end
                else if (band_hit)
                begin
                    cls = tccbs_pkg::CLASS_BAND;
                end
                else
                begin
                    cls = tccbs_pkg::CLASS_BACKGROUND;
                end
            end
        endcase
    end

    // raster position of the next pixel
    assign width_eff = (frame_width == '0) ? tccbs_pkg::FRAME_WIDTH_BITS'(1) : frame_width;
    assign col_inc = CW'(col_reg) + CW'(1);
    assign wrap = (col_inc >= CW'(width_eff)) || (&col_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (frame_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (wrap)
        begin
            col_next = '0;
            if (!(&row_reg))
            begin
                row_next = row_reg + COORD_BITS'(1);
            end
        end
        else
        begin
            col_next = col_inc[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_min_reg <= {3{tccbs_pkg::BOUND_MIN_RESET}};
            hand_max_reg <= {3{tccbs_pkg::BOUND_MAX_RESET}};
            band_min_reg <= {3{tccbs_pkg::BOUND_MIN_RESET}};
            band_max_reg <= {3{tccbs_pkg::BOUND_MAX_RESET}};
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (accept)
        begin
            hand_min_reg <= hand_min_next;
            hand_max_reg <= hand_max_next;
            band_min_reg <= band_min_next;
            band_max_reg <= band_max_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    assign item_ctrl.pixel_class = cls;
    assign item_ctrl.last        = frame_end;
    assign item_col              = col_reg;
    assign item_row              = row_reg;

endmodule

FILE: rtl/tccbs_queue.sv
module tccbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == CNW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

FILE: rtl/tccbs_back.sv
module tccbs_back #(
    parameter int COORD_BITS = 10,
    parameter int SUM_BITS   = 30
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  tccbs_pkg::item_ctrl_t                item_ctrl,
    input  logic [COORD_BITS-1:0]                item_col,
    input  logic [COORD_BITS-1:0]                item_row,
    output logic                                 empty,
    input  logic                                 pop,
    output tccbs_pkg::pixel_class_t              pixel_class,
    output logic                                 totals_valid,
    output logic [tccbs_pkg::COUNT_BITS-1:0]     hand_count,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] hand_sum_col,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] hand_sum_row,
    output logic [tccbs_pkg::COUNT_BITS-1:0]     band_count,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] band_sum_col,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] band_sum_row
);

    localparam int AW = (SUM_BITS > COORD_BITS ? SUM_BITS : COORD_BITS) + 1;
    localparam int XW =
        SUM_BITS > tccbs_pkg::FIELD_SUM_BITS ? SUM_BITS : tccbs_pkg::FIELD_SUM_BITS;
    localparam int CB = tccbs_pkg::COUNT_BITS;
    localparam int FB = tccbs_pkg::FIELD_SUM_BITS;

    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [SUM_BITS-1:0]   acc,
        input logic [COORD_BITS-1:0] coord
    );
        logic [AW-1:0] s;
        s = AW'(acc) + AW'(coord);
        return ((s >> SUM_BITS) != '0) ? '1 : s[SUM_BITS-1:0];
    endfunction

    function automatic logic [FB-1:0] to_field(input logic [SUM_BITS-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[FB-1:0];
    endfunction

    logic [CB-1:0]       h_cnt_reg, h_cnt_next, b_cnt_reg, b_cnt_next;
    logic [SUM_BITS-1:0] h_col_reg, h_col_next, h_row_reg, h_row_next;
    logic [SUM_BITS-1:0] b_col_reg, b_col_next, b_row_reg, b_row_next;

    logic                    valid_reg;
    tccbs_pkg::pixel_class_t class_reg;
    logic                    totals_reg;
    logic [CB-1:0]           o_h_cnt_reg, o_b_cnt_reg;
    logic [FB-1:0]           o_h_col_reg, o_h_row_reg, o_b_col_reg, o_b_row_reg;

    logic fire;
    logic [CB-1:0]       h_cnt_upd, b_cnt_upd;
    logic [SUM_BITS-1:0] h_col_upd, h_row_upd, b_col_upd, b_row_upd;

    assign fire  = !q_empty && (!valid_reg || pop);
    assign q_pop = fire;

    always_comb
    begin
        h_cnt_upd = h_cnt_reg;
        h_col_upd = h_col_reg;
        h_row_upd = h_row_reg;
        b_cnt_upd = b_cnt_reg;
        b_col_upd = b_col_reg;
        b_row_upd = b_row_reg;
        if (item_ctrl.pixel_class == tccbs_pkg::CLASS_HAND)
        begin
            h_cnt_upd = (&h_cnt_reg) ? h_cnt_reg : h_cnt_reg + CB'(1);
            h_col_upd = sat_add(h_col_reg, item_col);
            h_row_upd = sat_add(h_row_reg, item_row);
        end
        else if (item_ctrl.pixel_class == tccbs_pkg::CLASS_BAND)
        begin
            b_cnt_upd = (&b_cnt_reg) ? b_cnt_reg : b_cnt_reg + CB'(1);
            b_col_upd = sat_add(b_col_reg, item_col);
            b_row_upd = sat_add(b_row_reg, item_row);
        end
        if (item_ctrl.last)
        begin
            h_cnt_next = '0;
            h_col_next = '0;
            h_row_next = '0;
            b_cnt_next = '0;
            b_col_next = '0;
            b_row_next = '0;
        end
        else
        begin
            h_cnt_next = h_cnt_upd;
            h_col_next = h_col_upd;
            h_row_next = h_row_upd;
            b_cnt_next = b_cnt_upd;
            b_col_next = b_col_upd;
            b_row_next = b_row_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_cnt_reg <= '0;
            h_col_reg <= '0;
            h_row_reg <= '0;
            b_cnt_reg <= '0;
            b_col_reg <= '0;
            b_row_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                h_cnt_reg <= h_cnt_next;
                h_col_reg <= h_col_next;
                h_row_reg <= h_row_next;
                b_cnt_reg <= b_cnt_next;
                b_col_reg <= b_col_next;
                b_row_reg <= b_row_next;
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result register, totals zero unless frame end
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            class_reg  <= item_ctrl.pixel_class;
            totals_reg <= item_ctrl.last;
            if (item_ctrl.last)
            begin
                o_h_cnt_reg <= h_cnt_upd;
                o_h_col_reg <= to_field(h_col_upd);
                o_h_row_reg <= to_field(h_row_upd);
                o_b_cnt_reg <= b_cnt_upd;
                o_b_col_reg <= to_field(b_col_upd);
                o_b_row_reg <= to_field(b_row_upd);
            end
            else
            begin
                o_h_cnt_reg <= '0;
                o_h_col_reg <= '0;
                o_h_row_reg <= '0;
                o_b_cnt_reg <= '0;
                o_b_col_reg <= '0;
                o_b_row_reg <= '0;
            end
        end
    end

    assign empty        = !valid_reg;
    assign pixel_class  = class_reg;
    assign totals_valid = totals_reg;
    assign hand_count   = o_h_cnt_reg;
    assign hand_sum_col = o_h_col_reg;
    assign hand_sum_row = o_h_row_reg;
    assign band_count   = o_b_cnt_reg;
    assign band_sum_col = o_b_col_reg;
    assign band_sum_row = o_b_row_reg;

endmodule

FILE: rtl/two_class_color_box_segmenter.sv
// two-class color box segmenter
// input channel: queue-style push/full; one pixel with its operation per
// transaction (classify, learn hand box, learn band box) and a frame_end mark
// result channel: queue-style empty/pop; one result per input transaction,
// in order, with the pixel class and, on frame end, the frame's hand and band
// counts and column/row sums (zero otherwise)
// config: apb-style port, frame_width at byte address 0, write while idle
// throughput: one pixel per cycle while the queue is not full; the front
// end classifies and updates the learned boxes and raster position in the
// cycle a pixel is accepted, the back end updates the accumulators and
// loads the result register as it pops an item from the queue; an accepted
// pixel is written into the queue before the back end takes it
// a four-entry queue sits between front and back end; when pop is held low
// the result register holds, the queue fills and full rises after four more
// pixels; no transaction is lost or repeated
// reset: boxes go empty (min 255, max 0), position and totals to zero,
// frame_width to 640, the queue and the result register empty
module two_class_color_box_segmenter #(
    parameter int COORD_BITS = 10,
    parameter int SUM_BITS   = 30
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tccbs_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [tccbs_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [tccbs_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           operation,
    input  logic [7:0]                           blue,
    input  logic [7:0]                           green,
    input  logic [7:0]                           red,
    input  logic                                 frame_end,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [1:0]                           pixel_class,
    output logic                                 totals_valid,
    output logic [tccbs_pkg::COUNT_BITS-1:0]     hand_count,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] hand_sum_col,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] hand_sum_row,
    output logic [tccbs_pkg::COUNT_BITS-1:0]     band_count,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] band_sum_col,
    output logic [tccbs_pkg::FIELD_SUM_BITS-1:0] band_sum_row
);

    localparam int FWB = tccbs_pkg::FRAME_WIDTH_BITS;
    localparam int CTRL_W = $bits(tccbs_pkg::item_ctrl_t);
    localparam int QW = CTRL_W + 2 * COORD_BITS;
    localparam int QCW = $clog2(tccbs_pkg::QUEUE_DEPTH + 1);

    logic [FWB-1:0] frame_width_reg;
    logic [tccbs_pkg::REG_INDEX_BITS-1:0] reg_index;
    logic cfg_write;
    logic accept;

    tccbs_pkg::item_ctrl_t f_ctrl, b_ctrl;
    logic [COORD_BITS-1:0] f_col, f_row, b_col, b_row;
    logic [QW-1:0] q_wdata, q_rdata;
    logic q_empty, q_pop;
    logic [QCW-1:0] q_count;
    tccbs_pkg::pixel_class_t out_class;

    assign pready    = 1'b1;
    assign reg_index = paddr[tccbs_pkg::PADDR_BITS-1 -: tccbs_pkg::REG_INDEX_BITS];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= tccbs_pkg::FRAME_WIDTH_RESET;
        end
        else if (cfg_write && reg_index == tccbs_pkg::REG_FRAME_WIDTH)
        begin
            frame_width_reg <= pwdata[FWB-1:0];
        end
    end

    assign prdata = (reg_index == tccbs_pkg::REG_FRAME_WIDTH)
                  ? tccbs_pkg::PDATA_BITS'(frame_width_reg) : '0;

    assign accept = push && !full;

    tccbs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (operation),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .frame_end   (frame_end),
        .frame_width (frame_width_reg),
        .item_ctrl   (f_ctrl),
        .item_col    (f_col),
        .item_row    (f_row)
    );

    assign q_wdata = {f_ctrl, f_col, f_row};

    tccbs_queue #(
        .WIDTH (QW),
        .DEPTH (tccbs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (q_wdata),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    assign b_ctrl = tccbs_pkg::item_ctrl_t'(q_rdata[QW-1 -: CTRL_W]);
    assign b_col  = q_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign b_row  = q_rdata[COORD_BITS-1:0];

    tccbs_back #(
        .COORD_BITS (COORD_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .item_ctrl    (b_ctrl),
        .item_col     (b_col),
        .item_row     (b_row),
        .empty        (empty),
        .pop          (pop),
        .pixel_class  (out_class),
        .totals_valid (totals_valid),
        .hand_count   (hand_count),
        .hand_sum_col (hand_sum_col),
        .hand_sum_row (hand_sum_row),
        .band_count   (band_count),
        .band_sum_col (band_sum_col),
        .band_sum_row (band_sum_row)
    );

    assign pixel_class = out_class;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCW'(tccbs_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !totals_valid) |->
        (hand_count == '0 && hand_sum_col == '0 && hand_sum_row == '0 &&
         band_count == '0 && band_sum_col == '0 && band_sum_row == '0))
        else $error("totals not zero outside frame end");

    a_hand_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && totals_valid && out_class == tccbs_pkg::CLASS_HAND) |->
        hand_count != '0)
        else $error("frame-end hand pixel missing from totals");

    a_band_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && totals_valid && out_class == tccbs_pkg::CLASS_BAND) |->
        band_count != '0)
        else $error("frame-end band pixel missing from totals");
`endif

endmodule

FILE: tb/sv/segmenter_checker.sv
module segmenter_checker
    import tccbs_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int SUM_BITS   = 30
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_BITS-1:0]     paddr,
    input  logic [PDATA_BITS-1:0]     pwdata,
    input  logic [PDATA_BITS-1:0]     prdata,
    input  logic                      pready,
    input  logic                      push,
    input  logic                      full,
    input  logic [1:0]                operation,
    input  logic [7:0]                blue,
    input  logic [7:0]                green,
    input  logic [7:0]                red,
    input  logic                      frame_end,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [1:0]                pixel_class,
    input  logic                      totals_valid,
    input  logic [COUNT_BITS-1:0]     hand_count,
    input  logic [FIELD_SUM_BITS-1:0] hand_sum_col,
    input  logic [FIELD_SUM_BITS-1:0] hand_sum_row,
    input  logic [COUNT_BITS-1:0]     band_count,
    input  logic [FIELD_SUM_BITS-1:0] band_sum_col,
    input  logic [FIELD_SUM_BITS-1:0] band_sum_row,
    output int                        mismatches,
    output int                        pending,
    output int                        pixels_checked,
    output int                        frames_checked
);

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam longint unsigned SUM_MAX   = (64'd1 << SUM_BITS) - 1;
    localparam longint unsigned FIELD_MAX = (64'd1 << FIELD_SUM_BITS) - 1;
    localparam int              COORD_MAX = (1 << COORD_BITS) - 1;

    typedef struct {
        pixel_class_t    cls;
        logic            tv;
        longint unsigned totals [6];
    } pixel_label_t;

    pixel_label_t                 queued_labels [$];
    logic [FRAME_WIDTH_BITS-1:0]  frame_width;
    channels_t                    box_lo [2];
    channels_t                    box_hi [2];
    longint unsigned              acc [2][3];
    int                           col;
    int                           row;
    string total_names [6] = '{"hand_count", "hand_sum_col", "hand_sum_row",
                               "band_count", "band_sum_col", "band_sum_row"};

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                                longint unsigned lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic logic box_hit(int k, channels_t px);
        for (int c = 0; c < 3; c++)
        begin
            if (px[c] < box_lo[k][c] || px[c] > box_hi[k][c])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic segment_pixel();
        channels_t    px;
        pixel_label_t lbl;
        int           k;
        int           span;
        px = {red, green, blue};
        lbl.cls = CLASS_BACKGROUND;
        lbl.tv = 1'b0;
        lbl.totals = '{default: 0};
        if (operation == OP_LEARN_HAND || operation == OP_LEARN_BAND)
        begin
            k = (operation == OP_LEARN_HAND) ? 0 : 1;
            for (int c = 0; c < 3; c++)
            begin
                if (px[c] < box_lo[k][c])
                    box_lo[k][c] = px[c];
                if (px[c] > box_hi[k][c])
                    box_hi[k][c] = px[c];
            end
            lbl.cls = CLASS_LEARN;
        end
        else
        begin
            // hand box wins over band box
            for (k = 0; k < 2; k++)
            begin
                if (lbl.cls == CLASS_BACKGROUND && box_hit(k, px))
                begin
                    lbl.cls = (k == 0) ? CLASS_HAND : CLASS_BAND;
                    acc[k][0] = sat_add(acc[k][0], 1, COUNT_MAX);
                    acc[k][1] = sat_add(acc[k][1], col, SUM_MAX);
                    acc[k][2] = sat_add(acc[k][2], row, SUM_MAX);
                end
            end
        end
        if (frame_end)
        begin
            lbl.tv = 1'b1;
            for (k = 0; k < 2; k++)
            begin
                lbl.totals[3*k]     = acc[k][0] & COUNT_MAX;
                lbl.totals[3*k + 1] = acc[k][1] & FIELD_MAX;
                lbl.totals[3*k + 2] = acc[k][2] & FIELD_MAX;
                acc[k] = '{default: 0};
            end
            col = 0;
            row = 0;
        end
        else
        begin
            span = (frame_width == 0) ? 1 : int'(frame_width);
            if (col + 1 >= span || col >= COORD_MAX)
            begin
                col = 0;
                if (row < COORD_MAX)
                    row++;
            end
            else
                col++;
        end
        queued_labels.push_back(lbl);
    endtask

    task automatic compare_result();
        pixel_label_t    want;
        longint unsigned seen [6];
        if (queued_labels.size() == 0)
        begin
            $display("%0t mismatch unexpected result transaction, class %0d", $time,
                     pixel_class);
            mismatches++;
        end
        else
        begin
            want = queued_labels.pop_front();
            seen = '{hand_count, hand_sum_col, hand_sum_row,
                     band_count, band_sum_col, band_sum_row};
            check_field("pixel_class", want.cls, pixel_class);
            check_field("totals_valid", want.tv, totals_valid);
            for (int i = 0; i < 6; i++)
                check_field(total_names[i], want.totals[i], seen[i]);
            pixels_checked++;
            if (want.tv)
                frames_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_width = FRAME_WIDTH_RESET;
            for (int k = 0; k < 2; k++)
            begin
                box_lo[k] = {3{BOUND_MIN_RESET}};
                box_hi[k] = {3{BOUND_MAX_RESET}};
                acc[k] = '{default: 0};
            end
            col = 0;
            row = 0;
            queued_labels.delete();
            mismatches = 0;
            pixels_checked = 0;
            frames_checked = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[PADDR_BITS-1:2] == REG_FRAME_WIDTH)
                        frame_width = pwdata[FRAME_WIDTH_BITS-1:0];
                end
                else if (prdata != PDATA_BITS'(frame_width))
                begin
                    $display("%0t mismatch frame_width read expected %0d actual %0d", $time,
                             frame_width, prdata);
                    mismatches++;
                end
            end
            if (pop && !empty)
                compare_result();
            if (push && !full)
                segment_pixel();
        end
        pending = queued_labels.size();
    end

endmodule

FILE: tb/sv/two_class_color_box_segmenter_tb.sv
module two_class_color_box_segmenter_tb;

    import tccbs_pkg::*;

    localparam int         HALF_PERIOD = 4;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STEPS       = 6;
    localparam logic [FRAME_WIDTH_BITS-1:0] WIDTH_STEPS [STEPS] =
        '{11'd5, 11'd0, 11'd1024, 11'd1, 11'd2047, 11'd13};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_BITS-1:0]     paddr = '0;
    logic [PDATA_BITS-1:0]     pwdata = '0;
    logic [PDATA_BITS-1:0]     prdata;
    logic                      pready;
    logic                      push = 1'b0;
    logic                      full;
    logic [1:0]                operation = OP_CLASSIFY;
    logic [7:0]                blue = '0;
    logic [7:0]                green = '0;
    logic [7:0]                red = '0;
    logic                      frame_end = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [1:0]                pixel_class;
    logic                      totals_valid;
    logic [COUNT_BITS-1:0]     hand_count;
    logic [FIELD_SUM_BITS-1:0] hand_sum_col;
    logic [FIELD_SUM_BITS-1:0] hand_sum_row;
    logic [COUNT_BITS-1:0]     band_count;
    logic [FIELD_SUM_BITS-1:0] band_sum_col;
    logic [FIELD_SUM_BITS-1:0] band_sum_row;

    int mismatches;
    int pending;
    int pixels_checked;
    int frames_checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent = 0;

    two_class_color_box_segmenter u_dut (.*);

    segmenter_checker u_checker (.*);

    always #HALF_PERIOD clk = ~clk;

    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [7:0] shade(int kind);
        case (kind)
            0: return 8'($urandom_range(130, 60));
            1: return 8'($urandom_range(210, 130));
            3: return 8'($urandom_range(120, 70));
            4: return 8'($urandom_range(200, 140));
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_pixel(input logic [1:0] op, input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        operation <= op;
        blue <= b;
        green <= g;
        red <= r;
        frame_end <= last;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_frame(input int len);
        int         kind;
        int         roll;
        logic [1:0] op;
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(99);
            kind = $urandom_range(2);
            op = OP_CLASSIFY;
            if (roll < 5)
            begin
                op = OP_LEARN_HAND;
                kind = 3;
            end
            else if (roll < 10)
            begin
                op = OP_LEARN_BAND;
                kind = 4;
            end
            else if (roll < 15)
                op = OP_UNUSED;
            send_pixel(op, shade(kind), shade(kind), shade(kind), i == len - 1);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_FRAME_WIDTH, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int start;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apb_access(1'b0, '0);

        send_idle_pct = 10;
        recv_idle_pct = 80;
        // empty boxes, then hand box, unused op, band box, frame ends
        send_pixel(OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(OP_UNUSED, 8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(OP_LEARN_HAND, 8'd80, 8'd90, 8'd100, 1'b0);
        send_pixel(OP_LEARN_HAND, 8'd110, 8'd70, 8'd120, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd80, 8'd70, 8'd100, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd110, 8'd90, 8'd120, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd79, 8'd80, 8'd110, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd100, 8'd91, 8'd110, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd100, 8'd80, 8'd121, 1'b0);
        send_pixel(OP_UNUSED, 8'd95, 8'd80, 8'd110, 1'b0);
        send_pixel(OP_LEARN_BAND, 8'd150, 8'd160, 8'd170, 1'b0);
        send_pixel(OP_LEARN_BAND, 8'd190, 8'd200, 8'd210, 1'b1);
        send_pixel(OP_CLASSIFY, 8'd170, 8'd180, 8'd190, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd150, 8'd160, 8'd170, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd100, 8'd80, 8'd110, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(OP_CLASSIFY, 8'd200, 8'd200, 8'd200, 1'b1);
        send_pixel(OP_CLASSIFY, 8'd0, 8'd255, 8'd0, 1'b1);
        drain();

        for (int s = 0; s < STEPS; s++)
        begin
            send_idle_pct = (s < 2) ? 10 : (s < 4) ? 80 : 0;
            recv_idle_pct = (s < 2) ? 80 : (s < 4) ? 10 : 0;
            apb_access(1'b1, PDATA_BITS'(WIDTH_STEPS[s]));
            apb_access(1'b0, '0);
            if (s == 4)
            begin
                // band box opens to full range, hand still has priority
                send_pixel(OP_LEARN_BAND, 8'd0, 8'd0, 8'd0, 1'b0);
                send_pixel(OP_LEARN_BAND, 8'd255, 8'd255, 8'd255, 1'b0);
            end
            if (s == STEPS - 1)
            begin
                send_pixel(OP_LEARN_HAND, 8'd255, 8'd255, 8'd255, 1'b0);
                send_pixel(OP_LEARN_HAND, 8'd0, 8'd0, 8'd0, 1'b0);
            end
            start = sent;
            while (sent - start < 55)
                send_frame($urandom_range(30, 1));
            drain();
        end

        repeat (10) @(negedge clk);
        $display("covered %0d pixel transactions and %0d frame totals", pixels_checked,
                 frames_checked);
        $display("frame widths 0 to 2047, both boxes grown to full range, three stall patterns");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(HALF_PERIOD * 2 * 500000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tccbs_pkg.sv
rtl/tccbs_front.sv
rtl/tccbs_queue.sv
rtl/tccbs_back.sv
rtl/two_class_color_box_segmenter.sv
tb/sv/segmenter_checker.sv
tb/sv/two_class_color_box_segmenter_tb.sv
